[rtl/ddsh_pkg.sv]
// shared types, widths and constants for the differential drive slew limiter
// with heading hold; no dependencies
package ddsh_pkg;

  localparam int MUL_A_W      = 33;
  localparam int MUL_B_W      = 27;
  localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
  localparam int YAW_W        = 32;
  localparam int TGT_W        = 10;
  localparam int LVL_W        = 16;
  localparam int REQ_W        = 38;
  localparam int STEP_W       = 20;
  localparam int MS_W         = 11;
  localparam int INC_W        = 19;
  localparam int WORD_W       = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int LEVEL_MAX    = 25600;
  localparam int TIMER_MAX    = 2047;
  localparam int DIV100_SHIFT = 32;
  localparam logic [25:0] DIV100_RECIP = 26'd42949673;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_LEFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILT_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_PER_MS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_YAW_DEADBAND  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = 3'd7;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_DRIVE = 1'b1;

  typedef struct packed {
    logic [15:0] max_rpm_scale;
    logic        invert_left;
    logic        invert_right;
    logic [13:0] tilt_limit;
    logic [11:0] heading_gain;
    logic [9:0]  slew_per_ms;
    logic [13:0] yaw_deadband;
    logic [9:0]  update_period;
  } ddsh_cfg_t;

  typedef struct packed {
    logic               operation;
    logic signed [7:0]  speed;
    logic signed [7:0]  turn;
    logic signed [7:0]  trim_left;
    logic signed [7:0]  trim_right;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw_rate;
    logic [9:0]         elapsed_ms;
  } ddsh_item_t;

  typedef struct packed {
    logic                     write_valid;
    logic signed [WORD_W-1:0] left_speed_word;
    logic signed [WORD_W-1:0] right_speed_word;
  } ddsh_result_t;

endpackage

[rtl/diff_drive_slew_heading_hold_core.sv]
// differential drive slew limiter with heading hold, top level
// a control tick steps through S_RMUL, S_DIV, S_YAW, S_ERR, S_REQ, S_SL, S_SR,
// S_TMR, S_WL and S_WR to S_OUT, a drive command through S_CMD to S_OUT; a new item
// is taken only back in idle; a tick makes six passes through the one shared multiplier
// one result beat waits in an output register while the next beat runs
// reset (async, active low) restores register defaults and clears all drive state
module diff_drive_slew_heading_hold_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // speed, turn, trim_left, trim_right, pitch, yaw_rate, elapsed_ms, zero pad
  input  logic [79:0]                     s_axis_tdata,
  // operation
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // left_speed_word, right_speed_word
  output logic [47:0]                     m_axis_tdata,
  // write_valid
  output logic                            m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ddsh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ddsh_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ddsh_pkg::*;

  ddsh_cfg_t               cfg;
  ddsh_item_t              item;
  ddsh_result_t            res;
  ddsh_result_t            out_q;
  logic                    out_valid_q;
  logic                    idle;
  logic                    res_valid;
  logic                    res_ready;
  logic                    mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  always_comb begin
    item.operation  = s_axis_tuser;
    item.speed      = s_axis_tdata[7:0];
    item.turn       = s_axis_tdata[15:8];
    item.trim_left  = s_axis_tdata[23:16];
    item.trim_right = s_axis_tdata[31:24];
    item.pitch      = s_axis_tdata[47:32];
    item.yaw_rate   = s_axis_tdata[63:48];
    item.elapsed_ms = s_axis_tdata[73:64];
  end

  ddsh_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ddsh_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ddsh_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start_i     (s_axis_tvalid && s_axis_tready),
    .item_i      (item),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mul_en_o    (mul_en),
    .mul_a_o     (mul_a),
    .mul_b_o     (mul_b),
    .mul_p_i     (mul_p)
  );

  assign s_axis_tready = idle;
  assign res_ready     = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.write_valid;
  assign m_axis_tdata  = {out_q.right_speed_word, out_q.left_speed_word};

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a beat is in flight");

  a_quiet_words : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("speed words nonzero on a beat without write");

  a_out_from_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(res_valid))
    else $error("output beat raised without a sequencer result");

endmodule

[rtl/ddsh_cfg.sv]
// configuration register file, one register per index
// depends on ddsh_pkg
module ddsh_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ddsh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ddsh_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output ddsh_pkg::ddsh_cfg_t             cfg_o
);
  import ddsh_pkg::*;

  ddsh_cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_rpm_scale <= 16'd100;
      cfg_q.invert_left   <= 1'b0;
      cfg_q.invert_right  <= 1'b0;
      cfg_q.tilt_limit    <= 14'd4500;
      cfg_q.heading_gain  <= 12'd315;
      cfg_q.slew_per_ms   <= 10'd38;
      cfg_q.yaw_deadband  <= 14'd150;
      cfg_q.update_period <= 10'd50;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MAX_RPM_SCALE: cfg_q.max_rpm_scale <= cfg_data_i;
        REG_INVERT_LEFT:   cfg_q.invert_left   <= cfg_data_i[0];
        REG_INVERT_RIGHT:  cfg_q.invert_right  <= cfg_data_i[0];
        REG_TILT_LIMIT:    cfg_q.tilt_limit    <= cfg_data_i[13:0];
        REG_HEADING_GAIN:  cfg_q.heading_gain  <= cfg_data_i[11:0];
        REG_SLEW_PER_MS:   cfg_q.slew_per_ms   <= cfg_data_i[9:0];
        REG_YAW_DEADBAND:  cfg_q.yaw_deadband  <= cfg_data_i[13:0];
        REG_UPDATE_PERIOD: cfg_q.update_period <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/ddsh_mul.sv]
// shared signed multiplier with registered product
// depends on ddsh_pkg
module ddsh_mul (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [ddsh_pkg::MUL_A_W-1:0]     a_i,
  input  logic signed [ddsh_pkg::MUL_B_W-1:0]     b_i,
  output logic signed [ddsh_pkg::MUL_P_W-1:0]     p_o
);
  import ddsh_pkg::*;

  logic signed [MUL_P_W-1:0] p_q;

  assign p_o = p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
    end
  end

endmodule

[rtl/ddsh_seq.sv]
// sequencer holding drive state; steps one item through the shared multiplier
// depends on ddsh_pkg and drives ddsh_mul operands
module ddsh_seq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ddsh_pkg::ddsh_cfg_t                 cfg_i,
  input  logic                                start_i,
  input  ddsh_pkg::ddsh_item_t                item_i,
  output logic                                idle_o,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output ddsh_pkg::ddsh_result_t              res_o,
  output logic                                mul_en_o,
  output logic signed [ddsh_pkg::MUL_A_W-1:0] mul_a_o,
  output logic signed [ddsh_pkg::MUL_B_W-1:0] mul_b_o,
  input  logic signed [ddsh_pkg::MUL_P_W-1:0] mul_p_i
);
  import ddsh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CMD, S_RMUL, S_DIV, S_YAW, S_ERR, S_REQ,
    S_SL, S_SR, S_TMR, S_WL, S_WR, S_OUT
  } state_e;

  function automatic logic signed [7:0] sat100(input logic signed [7:0] v);
    logic signed [7:0] r;
    if (v > 8'sd100) r = 8'sd100;
    else if (v < -8'sd100) r = -8'sd100;
    else r = v;
    return r;
  endfunction

  function automatic logic signed [LVL_W-1:0] slew_f(
    input logic signed [LVL_W-1:0] cur,
    input logic signed [REQ_W-1:0] req,
    input logic [STEP_W-1:0]       step
  );
    logic signed [REQ_W-1:0] c;
    logic signed [REQ_W-1:0] s;
    logic signed [REQ_W-1:0] hi;
    logic signed [REQ_W-1:0] lo;
    s  = signed'({{(REQ_W-STEP_W){1'b0}}, step});
    c  = {{(REQ_W-LVL_W){cur[LVL_W-1]}}, cur};
    hi = c + s;
    lo = c - s;
    if (req > hi) c = hi;
    else if (req < lo) c = lo;
    else c = req;
    if (c > REQ_W'(LEVEL_MAX)) c = REQ_W'(LEVEL_MAX);
    if (c < -REQ_W'(LEVEL_MAX)) c = -REQ_W'(LEVEL_MAX);
    return c[LVL_W-1:0];
  endfunction

  function automatic logic signed [7:0] pct_f(input logic signed [LVL_W-1:0] lvl,
                                             input logic inv);
    logic signed [LVL_W-1:0] t;
    logic signed [7:0]       p;
    t = lvl + (lvl[LVL_W-1] ? LVL_W'(255) : LVL_W'(0));
    p = t[LVL_W-1:8];
    return inv ? -p : p;
  endfunction

  state_e                    state_q;
  ddsh_item_t                item_q;
  logic [YAW_W-1:0]          yaw_q;
  logic [YAW_W-1:0]          hold_q;
  logic                      hold_active_q;
  logic signed [TGT_W-1:0]   tgt_l_q;
  logic signed [TGT_W-1:0]   tgt_r_q;
  logic signed [7:0]         drive_q;
  logic signed [LVL_W-1:0]   lvl_l_q;
  logic signed [LVL_W-1:0]   lvl_r_q;
  logic                      was_moving_q;
  logic [MS_W-1:0]           ms_q;
  logic                      dead_q;
  logic                      neg_q;
  logic signed [REQ_W-1:0]   req_l_q;
  logic signed [REQ_W-1:0]   req_r_q;
  logic                      wr_q;
  logic [WORD_W-1:0]         word_l_q;

  logic signed [7:0]         sp, tu, tl, tr;
  logic signed [TGT_W-1:0]   tgt_l_n, tgt_r_n;
  logic                      lock_ok;
  logic [16:0]               rate_mag, pitch_mag;
  logic [MUL_P_W-1:0]        p_mag;
  logic [INC_W-1:0]          inc_mag;
  logic [YAW_W-1:0]          inc;
  logic [YAW_W-1:0]          err;
  logic signed [45:0]        pe, pc;
  logic signed [REQ_W-1:0]   corr, base_l, base_r;
  logic [MS_W:0]             ms_sum;
  logic [MS_W-1:0]           ms_sat;
  logic                      due, moving;
  logic signed [7:0]         pct_l, pct_r;

  always_comb begin
    sp = sat100(item_q.speed);
    tu = sat100(item_q.turn);
    tl = sat100(item_q.trim_left);
    tr = sat100(item_q.trim_right);
    tgt_l_n = {{(TGT_W-8){sp[7]}}, sp} + {{(TGT_W-8){tu[7]}}, tu}
            + {{(TGT_W-8){tl[7]}}, tl};
    tgt_r_n = {{(TGT_W-8){sp[7]}}, sp} - {{(TGT_W-8){tu[7]}}, tu}
            + {{(TGT_W-8){tr[7]}}, tr};
    lock_ok = (sp > 8'sd10 || sp < -8'sd10) && (tu < 8'sd5 && tu > -8'sd5);

    rate_mag  = item_q.yaw_rate[15] ? 17'(-{1'b1, item_q.yaw_rate})
                                    : {1'b0, item_q.yaw_rate};
    pitch_mag = item_q.pitch[15] ? 17'(-{1'b1, item_q.pitch}) : {1'b0, item_q.pitch};

    p_mag   = mul_p_i[MUL_P_W-1] ? MUL_P_W'(-mul_p_i) : MUL_P_W'(mul_p_i);
    inc_mag = mul_p_i[DIV100_SHIFT+INC_W-1:DIV100_SHIFT];
    inc     = neg_q ? YAW_W'(-{{(YAW_W-INC_W){1'b0}}, inc_mag})
                    : {{(YAW_W-INC_W){1'b0}}, inc_mag};
    err     = hold_q - yaw_q;

    pe   = mul_p_i[45:0];
    pc   = (pe + (pe[45] ? 46'sd1023 : 46'sd0)) >>> 10;
    corr = drive_q[7] ? -pc[REQ_W-1:0] : pc[REQ_W-1:0];
    base_l = {{(REQ_W-TGT_W-8){tgt_l_q[TGT_W-1]}}, tgt_l_q, 8'b0};
    base_r = {{(REQ_W-TGT_W-8){tgt_r_q[TGT_W-1]}}, tgt_r_q, 8'b0};

    ms_sum = {1'b0, ms_q} + {{(MS_W-9){1'b0}}, item_q.elapsed_ms};
    ms_sat = (ms_sum > (MS_W+1)'(TIMER_MAX)) ? MS_W'(TIMER_MAX) : ms_sum[MS_W-1:0];
    due    = ms_sat > {1'b0, cfg_i.update_period};
    moving = lvl_l_q > LVL_W'(256) || lvl_l_q < -LVL_W'(256)
          || lvl_r_q > LVL_W'(256) || lvl_r_q < -LVL_W'(256);

    pct_l = pct_f(lvl_l_q, cfg_i.invert_left);
    pct_r = pct_f(lvl_r_q, cfg_i.invert_right);
  end

  always_comb begin
    mul_en_o = 1'b0;
    mul_a_o  = '0;
    mul_b_o  = '0;
    case (state_q)
      S_RMUL: begin
        mul_en_o = 1'b1;
        mul_a_o  = MUL_A_W'(item_q.yaw_rate);
        mul_b_o  = {{(MUL_B_W-10){1'b0}}, item_q.elapsed_ms};
      end
      S_DIV: begin
        mul_en_o = 1'b1;
        mul_a_o  = {{(MUL_A_W-25){1'b0}}, p_mag[24:0]};
        mul_b_o  = {1'b0, DIV100_RECIP};
      end
      S_ERR: begin
        mul_en_o = 1'b1;
        mul_a_o  = {err[YAW_W-1], err};
        mul_b_o  = {{(MUL_B_W-12){1'b0}}, cfg_i.heading_gain};
      end
      S_REQ: begin
        mul_en_o = 1'b1;
        mul_a_o  = {{(MUL_A_W-10){1'b0}}, cfg_i.slew_per_ms};
        mul_b_o  = {{(MUL_B_W-10){1'b0}}, item_q.elapsed_ms};
      end
      S_WL: begin
        mul_en_o = 1'b1;
        mul_a_o  = MUL_A_W'(pct_l);
        mul_b_o  = {{(MUL_B_W-16){1'b0}}, cfg_i.max_rpm_scale};
      end
      S_WR: begin
        mul_en_o = 1'b1;
        mul_a_o  = MUL_A_W'(pct_r);
        mul_b_o  = {{(MUL_B_W-16){1'b0}}, cfg_i.max_rpm_scale};
      end
      default: ;
    endcase
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_o.write_valid      = wr_q;
  assign res_o.left_speed_word  = wr_q ? word_l_q : '0;
  assign res_o.right_speed_word = wr_q ? mul_p_i[WORD_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      item_q        <= '0;
      yaw_q         <= '0;
      hold_q        <= '0;
      hold_active_q <= 1'b0;
      tgt_l_q       <= '0;
      tgt_r_q       <= '0;
      drive_q       <= '0;
      lvl_l_q       <= '0;
      lvl_r_q       <= '0;
      was_moving_q  <= 1'b0;
      ms_q          <= '0;
      dead_q        <= 1'b0;
      neg_q         <= 1'b0;
      req_l_q       <= '0;
      req_r_q       <= '0;
      wr_q          <= 1'b0;
      word_l_q      <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            item_q  <= item_i;
            state_q <= (item_i.operation == OP_DRIVE) ? S_CMD : S_RMUL;
          end
        end
        S_CMD: begin
          drive_q <= sp;
          tgt_l_q <= tgt_l_n;
          tgt_r_q <= tgt_r_n;
          wr_q    <= 1'b0;
          if (lock_ok) begin
            if (!hold_active_q) begin
              hold_q        <= yaw_q;
              hold_active_q <= 1'b1;
            end
          end else begin
            hold_active_q <= 1'b0;
          end
          state_q <= S_OUT;
        end
        S_RMUL: begin
          dead_q  <= rate_mag > {3'b0, cfg_i.yaw_deadband};
          state_q <= S_DIV;
        end
        S_DIV: begin
          neg_q   <= mul_p_i[MUL_P_W-1];
          state_q <= S_YAW;
        end
        S_YAW: begin
          if (dead_q) yaw_q <= yaw_q + inc;
          state_q <= S_ERR;
        end
        S_ERR: begin
          state_q <= S_REQ;
        end
        S_REQ: begin
          if (pitch_mag > {3'b0, cfg_i.tilt_limit}) begin
            req_l_q <= '0;
            req_r_q <= '0;
            tgt_l_q <= '0;
            tgt_r_q <= '0;
          end else if (hold_active_q) begin
            req_l_q <= base_l - corr;
            req_r_q <= base_r + corr;
          end else begin
            req_l_q <= base_l;
            req_r_q <= base_r;
          end
          state_q <= S_SL;
        end
        S_SL: begin
          lvl_l_q <= slew_f(lvl_l_q, req_l_q, mul_p_i[STEP_W-1:0]);
          state_q <= S_SR;
        end
        S_SR: begin
          lvl_r_q <= slew_f(lvl_r_q, req_r_q, mul_p_i[STEP_W-1:0]);
          state_q <= S_TMR;
        end
        S_TMR: begin
          wr_q <= 1'b0;
          if (due) begin
            ms_q <= '0;
            if (moving || was_moving_q) begin
              wr_q         <= 1'b1;
              was_moving_q <= moving;
            end
          end else begin
            ms_q <= ms_sat;
          end
          state_q <= S_WL;
        end
        S_WL: begin
          state_q <= S_WR;
        end
        S_WR: begin
          word_l_q <= mul_p_i[WORD_W-1:0];
          state_q  <= S_OUT;
        end
        S_OUT: begin
          if (res_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/ddsh_motor_word_checker.sv]
`timescale 1ns / 100ps
// checker for the differential drive slew limiter: watches the config, item and
// result channels, predicts each result beat and compares it; needs ddsh_pkg
module ddsh_motor_word_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  // speed, turn, trim_left, trim_right, pitch, yaw_rate, elapsed_ms, zero pad
  input  logic [79:0]                     s_tdata_i,
  // operation
  input  logic                            s_tuser_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  // left_speed_word, right_speed_word
  input  logic [47:0]                     m_tdata_i,
  // write_valid
  input  logic                            m_tuser_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [ddsh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ddsh_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              mismatches_o,
  output int                              words_pending_o
);
  import ddsh_pkg::*;

  int rpm_scale, tilt_limit, heading_gain, slew_per_ms, yaw_deadband, update_period;
  bit inv_left, inv_right;

  logic [31:0] yaw_mdeg, heading_ref;
  bit          lock_armed, moved_last;
  int          tgt_left, tgt_right, cmd_speed, lvl_left, lvl_right, since_write;

  ddsh_result_t motor_word_q[$];
  int           word_mismatches;

  function automatic int clamp_pct(input int v);
    return v > 100 ? 100 : (v < -100 ? -100 : v);
  endfunction

  function automatic int abs_int(input int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int slew_level(input int cur, input longint req, input longint lim);
    longint c;
    c = cur;
    if (req > c + lim) c = c + lim;
    else if (req < c - lim) c = c - lim;
    else c = req;
    if (c > LEVEL_MAX) c = LEVEL_MAX;
    if (c < -LEVEL_MAX) c = -LEVEL_MAX;
    return int'(c);
  endfunction

  function automatic logic [WORD_W-1:0] speed_word(input int level, input bit inv);
    longint pct;
    longint prod;
    pct = level / 256;
    if (inv) pct = -pct;
    prod = pct * rpm_scale;
    return prod[WORD_W-1:0];
  endfunction

  function automatic ddsh_result_t advance_drive_model(input ddsh_item_t it);
    ddsh_result_t res;
    int          sp, tu, tl, tr, pitch_v, rate_v, el;
    longint      inc, req_l, req_r, err, corr, lim;
    logic [31:0] diff;
    bit          moving;
    res = '0;
    if (it.operation == OP_DRIVE) begin
      sp = clamp_pct(it.speed);
      tu = clamp_pct(it.turn);
      tl = clamp_pct(it.trim_left);
      tr = clamp_pct(it.trim_right);
      cmd_speed = sp;
      tgt_left = sp + tu + tl;
      tgt_right = sp - tu + tr;
      if (abs_int(sp) > 10 && abs_int(tu) < 5) begin
        if (!lock_armed) begin
          heading_ref = yaw_mdeg;
          lock_armed = 1'b1;
        end
      end else begin
        lock_armed = 1'b0;
      end
      return res;
    end
    pitch_v = it.pitch;
    rate_v = it.yaw_rate;
    el = it.elapsed_ms;
    if (abs_int(rate_v) > yaw_deadband) begin
      inc = (longint'(rate_v) * el) / 100;
      yaw_mdeg = yaw_mdeg + inc[31:0];
    end
    req_l = longint'(tgt_left) * 256;
    req_r = longint'(tgt_right) * 256;
    if (abs_int(pitch_v) > tilt_limit) begin
      req_l = 0;
      req_r = 0;
      tgt_left = 0;
      tgt_right = 0;
    end else if (lock_armed) begin
      diff = heading_ref - yaw_mdeg;
      err = longint'($signed(diff));
      corr = (err * heading_gain) / 1024;
      if (cmd_speed < 0) corr = -corr;
      req_l = req_l - corr;
      req_r = req_r + corr;
    end
    lim = longint'(slew_per_ms) * el;
    lvl_left = slew_level(lvl_left, req_l, lim);
    lvl_right = slew_level(lvl_right, req_r, lim);
    since_write = since_write + el;
    if (since_write > TIMER_MAX) since_write = TIMER_MAX;
    if (since_write > update_period) begin
      moving = abs_int(lvl_left) > 256 || abs_int(lvl_right) > 256;
      since_write = 0;
      if (moving || moved_last) begin
        res.write_valid = 1'b1;
        res.left_speed_word = speed_word(lvl_left, inv_left);
        res.right_speed_word = speed_word(lvl_right, inv_right);
        moved_last = moving;
      end
    end
    return res;
  endfunction

  task automatic report_word_mismatch(input string what, input logic [WORD_W-1:0] got,
                                      input logic [WORD_W-1:0] want);
    $display("%0t mismatch on %s: got %0h expected %0h", $time, what, got, want);
    word_mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    ddsh_item_t   beat_in;
    ddsh_result_t want;
    if (!rst_ni) begin
      rpm_scale = 100;
      inv_left = 1'b0;
      inv_right = 1'b0;
      tilt_limit = 4500;
      heading_gain = 315;
      slew_per_ms = 38;
      yaw_deadband = 150;
      update_period = 50;
      yaw_mdeg = '0;
      heading_ref = '0;
      lock_armed = 1'b0;
      moved_last = 1'b0;
      tgt_left = 0;
      tgt_right = 0;
      cmd_speed = 0;
      lvl_left = 0;
      lvl_right = 0;
      since_write = 0;
      motor_word_q.delete();
      word_mismatches = 0;
      mismatches_o <= 0;
      words_pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_MAX_RPM_SCALE: rpm_scale = cfg_data_i;
          REG_INVERT_LEFT:   inv_left = cfg_data_i[0];
          REG_INVERT_RIGHT:  inv_right = cfg_data_i[0];
          REG_TILT_LIMIT:    tilt_limit = cfg_data_i[13:0];
          REG_HEADING_GAIN:  heading_gain = cfg_data_i[11:0];
          REG_SLEW_PER_MS:   slew_per_ms = cfg_data_i[9:0];
          REG_YAW_DEADBAND:  yaw_deadband = cfg_data_i[13:0];
          REG_UPDATE_PERIOD: update_period = cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (motor_word_q.size() == 0) begin
          report_word_mismatch("result with no expectation", m_tdata_i[23:0], '0);
        end else begin
          want = motor_word_q.pop_front();
          if (m_tuser_i !== want.write_valid)
            report_word_mismatch("write_valid", {23'd0, m_tuser_i}, {23'd0, want.write_valid});
          if (m_tdata_i[23:0] !== want.left_speed_word)
            report_word_mismatch("left_speed_word", m_tdata_i[23:0], want.left_speed_word);
          if (m_tdata_i[47:24] !== want.right_speed_word)
            report_word_mismatch("right_speed_word", m_tdata_i[47:24], want.right_speed_word);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        beat_in.operation = s_tuser_i;
        beat_in.speed = s_tdata_i[7:0];
        beat_in.turn = s_tdata_i[15:8];
        beat_in.trim_left = s_tdata_i[23:16];
        beat_in.trim_right = s_tdata_i[31:24];
        beat_in.pitch = s_tdata_i[47:32];
        beat_in.yaw_rate = s_tdata_i[63:48];
        beat_in.elapsed_ms = s_tdata_i[73:64];
        motor_word_q.push_back(advance_drive_model(beat_in));
      end
      mismatches_o <= word_mismatches;
      words_pending_o <= motor_word_q.size();
    end
  end

endmodule

[tb/diff_drive_slew_heading_hold_core_test.sv]
`timescale 1ns / 100ps
// stimulus and verdict for diff_drive_slew_heading_hold_core: directed and random
// commands and ticks over several register settings; needs ddsh_pkg and the checker
module diff_drive_slew_heading_hold_core_test;
  import ddsh_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  // speed, turn, trim_left, trim_right, pitch, yaw_rate, elapsed_ms, zero pad
  logic [79:0]           s_axis_tdata;
  // operation
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  // left_speed_word, right_speed_word
  logic [47:0]           m_axis_tdata;
  // write_valid
  logic                  m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int mismatches;
  int words_pending;
  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;

  diff_drive_slew_heading_hold_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  ddsh_motor_word_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .s_tuser_i       (s_axis_tuser),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .m_tuser_i       (m_axis_tuser),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mismatches_o    (mismatches),
    .words_pending_o (words_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
    end
  end

  function automatic ddsh_item_t make_drive(input int sp, input int tu, input int tl,
                                            input int tr);
    ddsh_item_t it;
    it.operation = OP_DRIVE;
    it.speed = sp[7:0];
    it.turn = tu[7:0];
    it.trim_left = tl[7:0];
    it.trim_right = tr[7:0];
    it.pitch = 16'($urandom);
    it.yaw_rate = 16'($urandom);
    it.elapsed_ms = 10'($urandom);
    return it;
  endfunction

  function automatic ddsh_item_t make_tick(input int pv, input int yr, input int el);
    ddsh_item_t it;
    it.operation = OP_TICK;
    it.speed = 8'($urandom);
    it.turn = 8'($urandom);
    it.trim_left = 8'($urandom);
    it.trim_right = 8'($urandom);
    it.pitch = pv[15:0];
    it.yaw_rate = yr[15:0];
    it.elapsed_ms = el[9:0];
    return it;
  endfunction

  task automatic push_item(input ddsh_item_t it);
    int gap;
    gap = 0;
    while (int'($urandom_range(99)) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.operation;
    s_axis_tdata <= {6'd0, it.elapsed_ms, it.yaw_rate, it.pitch, it.trim_right,
                     it.trim_left, it.turn, it.speed};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_for_all_words();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (words_pending != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_settings(input ddsh_cfg_t c);
    write_register(REG_MAX_RPM_SCALE, c.max_rpm_scale);
    write_register(REG_INVERT_LEFT, {15'd0, c.invert_left});
    write_register(REG_INVERT_RIGHT, {15'd0, c.invert_right});
    write_register(REG_TILT_LIMIT, {2'd0, c.tilt_limit});
    write_register(REG_HEADING_GAIN, {4'd0, c.heading_gain});
    write_register(REG_SLEW_PER_MS, {6'd0, c.slew_per_ms});
    write_register(REG_YAW_DEADBAND, {2'd0, c.yaw_deadband});
    write_register(REG_UPDATE_PERIOD, {6'd0, c.update_period});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input int count);
    ddsh_item_t it;
    int sp, tu, tl, tr, pv, yr, el, sel;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_for_all_words();
      sel = $urandom_range(99);
      if (sel < 25) begin
        sel = $urandom_range(99);
        if (sel < 50) begin
          sp = int'($urandom_range(11, 100)) * ($urandom_range(1) ? 1 : -1);
          tu = int'($urandom_range(8)) - 4;
        end else if (sel < 80) begin
          sp = int'($urandom_range(200)) - 100;
          tu = int'($urandom_range(200)) - 100;
        end else begin
          sp = int'($urandom_range(255)) - 128;
          tu = int'($urandom_range(255)) - 128;
        end
        if ($urandom_range(9) == 0) begin
          tl = int'($urandom_range(255)) - 128;
          tr = int'($urandom_range(255)) - 128;
        end else begin
          tl = int'($urandom_range(20)) - 10;
          tr = int'($urandom_range(20)) - 10;
        end
        it = make_drive(sp, tu, tl, tr);
      end else begin
        sel = $urandom_range(99);
        if (sel < 80) pv = int'($urandom_range(6000)) - 3000;
        else if (sel < 90) pv = int'($urandom_range(20000)) - 10000;
        else pv = int'($urandom_range(65535)) - 32768;
        if ($urandom_range(9) < 7) yr = int'($urandom_range(6000)) - 3000;
        else yr = int'($urandom_range(65535)) - 32768;
        sel = $urandom_range(99);
        if (sel < 85) el = $urandom_range(1, 30);
        else if (sel < 95) el = $urandom_range(1023);
        else el = $urandom_range(1) ? 1023 : 0;
        it = make_tick(pv, yr, el);
      end
      push_item(it);
    end
  endtask

  initial begin
    ddsh_cfg_t plan [6];
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    plan[0] = '{16'd100, 1'b0, 1'b0, 14'd4500, 12'd315, 10'd38, 14'd150, 10'd50};
    plan[1] = '{16'd65535, 1'b1, 1'b1, 14'd9000, 12'd4095, 10'd1023, 14'd10000, 10'd1000};
    plan[2] = '{16'd0, 1'b0, 1'b1, 14'd0, 12'd0, 10'd0, 14'd0, 10'd0};
    plan[3] = '{16'd1, 1'b1, 1'b0, 14'd16383, 12'd4095, 10'd1, 14'd0, 10'd1};
    plan[4] = '{16'($urandom), 1'($urandom), 1'($urandom), 14'($urandom_range(9000)),
                12'($urandom), 10'($urandom), 14'($urandom_range(10000)),
                10'($urandom_range(1, 1000))};
    plan[5] = '{16'd250, 1'b0, 1'b1, 14'd3000, 12'd2000, 10'd200, 14'd500, 10'd20};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 36;
    recv_idle_pct = 46;
    push_item(make_drive(127, -128, 127, -128));
    push_item(make_tick(0, 0, 0));
    push_item(make_tick(0, 32767, 1023));
    push_item(make_drive(50, 0, 0, 0));
    push_item(make_drive(60, 4, -3, 3));
    push_item(make_tick(4500, -32768, 100));
    push_item(make_tick(4501, 2000, 60));
    push_item(make_tick(-18000, 2000, 60));
    push_item(make_drive(-50, 0, 0, 0));
    push_item(make_tick(0, 151, 60));
    push_item(make_tick(0, 150, 60));
    push_item(make_tick(-4500, -151, 60));
    push_item(make_tick(32767, 500, 60));
    push_item(make_tick(-32768, 500, 60));
    push_item(make_drive(10, 0, 0, 0));
    push_item(make_tick(0, -3000, 40));
    push_item(make_drive(0, 0, 0, 0));
    push_item(make_tick(0, 0, 1023));
    push_item(make_tick(0, 0, 1023));
    push_item(make_drive(-128, 127, -128, -128));
    push_item(make_tick(100, 0, 5));
    push_item(make_tick(-100, 0, 1023));
    push_item(make_drive(100, -100, 100, 100));
    push_item(make_tick(0, 0, 1023));

    for (int p = 0; p < 6; p++) begin
      wait_for_all_words();
      repeat (4) @(posedge clk_i);
      case (p / 2)
        0: begin
          send_idle_pct = 36;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 36;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      apply_settings(plan[p]);
      run_phase(108);
    end

    wait_for_all_words();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ddsh_pkg.sv
rtl/ddsh_cfg.sv
rtl/ddsh_mul.sv
rtl/ddsh_seq.sv
rtl/diff_drive_slew_heading_hold_core.sv
tb/ddsh_motor_word_checker.sv
tb/diff_drive_slew_heading_hold_core_test.sv
